// ===== design/sfk_pkg.sv =====
// Package for skeleton forward kinematics: fixed-point constants, CORDIC table,
// rounding and saturation helpers. No dependencies.
package sfk_pkg;

  localparam int unsigned MaxJoints = 64;
  localparam int unsigned CordicSteps = 23;
  localparam logic signed [31:0] DegFull  = 32'sd23592960;
  localparam logic signed [31:0] DegHalf  = 32'sd11796480;
  localparam logic signed [31:0] DegQuart = 32'sd5898240;
  localparam logic signed [31:0] OneQ30   = 32'sd1073741824;
  localparam logic signed [31:0] CordicGain = 32'sd652032874;

  function automatic logic signed [31:0] atan_step(input logic [4:0] i);
    logic signed [31:0] v;
    unique case (i)
      5'd0:  v = 32'sd2949120;
      5'd1:  v = 32'sd1740967;
      5'd2:  v = 32'sd919879;
      5'd3:  v = 32'sd466945;
      5'd4:  v = 32'sd234379;
      5'd5:  v = 32'sd117304;
      5'd6:  v = 32'sd58666;
      5'd7:  v = 32'sd29335;
      5'd8:  v = 32'sd14668;
      5'd9:  v = 32'sd7334;
      5'd10: v = 32'sd3667;
      5'd11: v = 32'sd1833;
      5'd12: v = 32'sd917;
      5'd13: v = 32'sd458;
      5'd14: v = 32'sd229;
      5'd15: v = 32'sd115;
      5'd16: v = 32'sd57;
      5'd17: v = 32'sd29;
      5'd18: v = 32'sd14;
      5'd19: v = 32'sd7;
      5'd20: v = 32'sd4;
      5'd21: v = 32'sd2;
      5'd22: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // Round a Q2.30 x Q product to Q: floor((p + 2^29) / 2^30)
  function automatic logic signed [35:0] rnd30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd536870912) >>> 30;
    return t[35:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sh7fffffff;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== design/sfk_cordic.sv =====
// Iterative sin/cos in Q2.30 from Q16.16 degrees, one micro-rotation per cycle.
// Depends on sfk_pkg.
module sfk_cordic import sfk_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] angle_i,
  output logic               done_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMod  = 3'd1;
  localparam logic [2:0] StRed  = 3'd2;
  localparam logic [2:0] StRot  = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;

  // 92 full turns: lifts any negative 32-bit angle to a non-negative one
  localparam logic signed [32:0] ModBias = 33'sd2170552320;

  logic [2:0] state_q, state_d;
  logic [4:0] it_q, it_d;
  logic signed [32:0] x_q, x_d, y_q, y_d, r_q, r_d;
  logic neg_q, neg_d, zero_q, zero_d;
  logic signed [32:0] rr;
  logic signed [32:0] turns;

  always_comb begin
    state_d = state_q; it_d = it_q; x_d = x_q; y_d = y_q; r_d = r_q;
    neg_d = neg_q; zero_d = zero_q; done_o = 1'b0;
    rr = 33'sd0;
    turns = 33'(DegFull) <<< it_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          r_d = (angle_i < 0) ? 33'(angle_i) + ModBias : 33'(angle_i);
          it_d = 5'd6;
          state_d = StMod;
        end
      end
      StMod: begin
        // restoring reduction by 64, 32 .. 1 full turns
        if (r_q >= turns) r_d = r_q - turns;
        it_d = it_q - 5'd1;
        if (it_q == 5'd0) state_d = StRed;
      end
      StRed: begin
        rr = r_q;
        zero_d = (rr == 0);
        neg_d = 1'b0;
        if (rr >= 33'(DegHalf)) rr = rr - 33'(DegFull);
        if (rr > 33'(DegQuart)) begin
          rr = rr - 33'(DegHalf); neg_d = 1'b1;
        end else if (rr < -33'(DegQuart)) begin
          rr = rr + 33'(DegHalf); neg_d = 1'b1;
        end
        r_d = rr; x_d = 33'(CordicGain); y_d = 33'sd0; it_d = 5'd0;
        state_d = StRot;
      end
      StRot: begin
        if (r_q >= 0) begin
          x_d = x_q - (y_q >>> it_q); y_d = y_q + (x_q >>> it_q);
          r_d = r_q - 33'(atan_step(it_q));
        end else begin
          x_d = x_q + (y_q >>> it_q); y_d = y_q - (x_q >>> it_q);
          r_d = r_q + 33'(atan_step(it_q));
        end
        it_d = it_q + 5'd1;
        if (it_q == 5'(CordicSteps - 1)) state_d = StFin;
      end
      StFin: begin
        done_o = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    if (zero_q) begin
      cos_o = OneQ30; sin_o = 32'sd0;
    end else if (neg_q) begin
      cos_o = 32'(-x_q); sin_o = 32'(-y_q);
    end else begin
      cos_o = 32'(x_q); sin_o = 32'(y_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d; x_q <= x_d; y_q <= y_d; r_q <= r_d;
    neg_q <= neg_d; zero_q <= zero_d;
  end

endmodule

// ===== design/skeleton_forward_kinematics.sv =====
// Skeleton forward kinematics top level: sequencer, shared multiplier, joint store.
// Depends on sfk_pkg and sfk_cordic.
//
//  channel | signals                          | direction
//  input   | in_valid_i / in_stall_o + fields | into block
//  output  | out_valid_o / out_stall_i + fields | out of block
//
// out_valid_o rises, after the input transfer, once three CORDIC runs (each with
// a modulo-360 reduction), the two multiply passes for the local rotation, the
// parent reads (skipped for a root), the rotation and position passes of the world
// transform and the store writes are done, all on one 32x32 multiplier.
// Reset clears the sequencer and output valid; the stores are left unset.
// in_stall_o is high from acceptance until the cycle after the result transfer.
module skeleton_forward_kinematics import sfk_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [5:0]         joint_index_i,
  input  logic [5:0]         parent_index_i,
  input  logic               is_root_i,
  input  logic signed [31:0] offset_x_i,
  input  logic signed [31:0] offset_y_i,
  input  logic signed [31:0] offset_z_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] angle_x_i,
  input  logic signed [31:0] angle_y_i,
  input  logic signed [31:0] angle_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         out_joint_o,
  output logic signed [31:0] world_x_o,
  output logic signed [31:0] world_y_o,
  output logic signed [31:0] world_z_o,
  output logic signed [31:0] out_angle_x_o,
  output logic signed [31:0] out_angle_y_o,
  output logic signed [31:0] out_angle_z_o
);

  localparam int unsigned JW = (MaxJoints > 1) ? $clog2(MaxJoints) : 1;
  localparam int unsigned RotDepth = MaxJoints * 9;
  localparam int unsigned PosDepth = MaxJoints * 3;
  localparam int unsigned RaW = $clog2(RotDepth);
  localparam int unsigned PaW = $clog2(PosDepth);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StCor  = 4'd1;
  localparam logic [3:0] StMul  = 4'd2;
  localparam logic [3:0] StRdP  = 4'd3;
  localparam logic [3:0] StWr   = 4'd4;
  localparam logic [3:0] StOut  = 4'd5;

  logic [3:0] state_q, state_d;
  logic [1:0] ang_q, ang_d;        // which CORDIC run
  logic       cr_q, cr_d;          // CORDIC run in progress
  logic [1:0] ph_q, ph_d;          // 0: Rz*Rx, 1: *Ry, 2: parent rot, 3: parent pos
  logic [1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic       mv_q, mv_d;          // multiplier result pending
  logic [4:0] rd_q, rd_d;          // parent read counter
  logic [3:0] wi_q, wi_d;
  logic       ov_q, ov_d;

  logic [5:0] jraw_q;
  logic [JW-1:0] jix_q, pix_q;
  logic root_q;
  logic signed [31:0] t_q [3];
  logic signed [31:0] ax_q, ay_q, az_q;
  logic signed [31:0] cs_q [3], sn_q [3];
  logic signed [31:0] a_q [9], l_q [9], w_q [9], pr_q [9];
  logic signed [31:0] pp_q [3], wp_q [3];
  logic signed [35:0] acc_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] mop_a, mop_b;

  logic signed [31:0] rot_mem [RotDepth];
  logic signed [31:0] pos_mem [PosDepth];
  logic signed [31:0] rrd_q, prd_q;

  logic cor_start, cor_done;
  logic signed [31:0] cor_ang, cor_c, cor_s;

  sfk_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(cor_start), .angle_i(cor_ang),
    .done_o(cor_done), .cos_o(cor_c), .sin_o(cor_s)
  );

  always_comb begin
    unique case (ang_q)
      2'd0: cor_ang = ax_q;
      2'd1: cor_ang = ay_q;
      default: cor_ang = az_q;
    endcase
  end

  function automatic logic signed [31:0] rz_e(input logic [3:0] n,
      input logic signed [31:0] c, input logic signed [31:0] s);
    logic signed [31:0] v;
    unique case (n)
      4'd0: v = c;  4'd1: v = -s; 4'd3: v = s; 4'd4: v = c; 4'd8: v = OneQ30;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction
  function automatic logic signed [31:0] rx_e(input logic [3:0] n,
      input logic signed [31:0] c, input logic signed [31:0] s);
    logic signed [31:0] v;
    unique case (n)
      4'd0: v = OneQ30; 4'd4: v = c; 4'd5: v = -s; 4'd7: v = s; 4'd8: v = c;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction
  function automatic logic signed [31:0] ry_e(input logic [3:0] n,
      input logic signed [31:0] c, input logic signed [31:0] s);
    logic signed [31:0] v;
    unique case (n)
      4'd0: v = c; 4'd2: v = s; 4'd4: v = OneQ30; 4'd6: v = -s; 4'd8: v = c;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // operands are formed from the next indices so prod_q matches i/j/k
  logic [3:0] ik, kj;
  always_comb begin
    ik = 4'(i_d) * 4'd3 + 4'(k_d);
    kj = 4'(k_d) * 4'd3 + 4'(j_d);
    unique case (ph_d)
      2'd0: begin
        mop_a = rz_e(ik, cs_q[2], sn_q[2]); mop_b = rx_e(kj, cs_q[0], sn_q[0]);
      end
      2'd1: begin
        mop_a = a_q[ik]; mop_b = ry_e(kj, cs_q[1], sn_q[1]);
      end
      2'd2: begin
        mop_a = pr_q[ik]; mop_b = l_q[kj];
      end
      default: begin
        mop_a = pr_q[ik]; mop_b = t_q[k_d];
      end
    endcase
  end

  logic signed [35:0] acc_n;
  logic last_k, last_j, last_i;
  logic [RaW-1:0] raddr;
  logic [PaW-1:0] paddr;
  logic [4:0] rdm;

  always_comb begin
    state_d = state_q; ang_d = ang_q; ph_d = ph_q; i_d = i_q; j_d = j_q;
    k_d = k_q; mv_d = 1'b0; rd_d = rd_q; wi_d = wi_q; ov_d = ov_q;
    cr_d = cr_q;
    cor_start = 1'b0;
    acc_n = acc_q + rnd30(prod_q);
    last_k = (k_q == 2'd2);
    last_j = (ph_q == 2'd3) || (j_q == 2'd2);
    last_i = (i_q == 2'd2);
    rdm = rd_q - 5'd1;
    raddr = RaW'(32'(pix_q) * 9 + 32'(rd_q));
    paddr = PaW'(32'(pix_q) * 3 + 32'(rd_q) - 32'd9);
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StCor; ang_d = 2'd0;
        end
      end
      StCor: begin
        if (!cr_q) begin
          cor_start = 1'b1; cr_d = 1'b1;
        end else if (cor_done) begin
          cr_d = 1'b0;
          if (ang_q == 2'd2) begin
            state_d = StMul; ph_d = 2'd0; i_d = '0; j_d = '0; k_d = '0;
          end else begin
            ang_d = ang_q + 2'd1;
          end
        end
      end
      StMul: begin
        // prod_q holds the previous step's product while the next is formed
        if (!mv_q) begin
          mv_d = 1'b1;
        end else begin
          mv_d = 1'b1;
          if (last_k) begin
            if (last_j && last_i) mv_d = 1'b0;
            k_d = '0;
            if (last_j) begin
              j_d = '0;
              i_d = last_i ? 2'd0 : i_q + 2'd1;
            end else j_d = j_q + 2'd1;
            if (last_j && last_i) begin
              unique case (ph_q)
                2'd0: ph_d = 2'd1;
                2'd1: begin
                  if (root_q) ph_d = 2'd2;
                  else begin state_d = StRdP; rd_d = '0; end
                end
                2'd2: ph_d = 2'd3;
                default: begin state_d = StWr; wi_d = '0; end
              endcase
            end
          end else k_d = k_q + 2'd1;
        end
      end
      StRdP: begin
        // registered reads: data for address n arrives in the following cycle
        rd_d = rd_q + 5'd1;
        if (rd_q == 5'd12) begin
          state_d = StMul; ph_d = 2'd2; i_d = '0; j_d = '0; k_d = '0;
        end
      end
      StWr: begin
        wi_d = wi_q + 4'd1;
        if (wi_q == 4'd11) begin state_d = StOut; ov_d = 1'b1; end
      end
      StOut: begin
        if (!out_stall_i) begin ov_d = 1'b0; state_d = StIdle; end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; ang_q <= '0; ph_q <= '0; i_q <= '0; j_q <= '0;
      k_q <= '0; mv_q <= 1'b0; rd_q <= '0; wi_q <= '0; ov_q <= 1'b0;
      cr_q <= 1'b0;
    end else begin
      state_q <= state_d; ang_q <= ang_d; ph_q <= ph_d; i_q <= i_d; j_q <= j_d;
      k_q <= k_d; mv_q <= mv_d; rd_q <= rd_d; wi_q <= wi_d; ov_q <= ov_d;
      cr_q <= cr_d;
    end
  end

  // Write-back addresses for the store sweep
  logic [RaW-1:0] wra;
  logic [PaW-1:0] wpa;
  always_comb begin
    wra = RaW'(32'(jix_q) * 9 + 32'(wi_q));
    wpa = PaW'(32'(jix_q) * 3 + 32'(wi_q) - 32'd9);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      jraw_q <= joint_index_i;
      jix_q <= JW'(32'(joint_index_i) % MaxJoints);
      pix_q <= JW'(32'(parent_index_i) % MaxJoints);
      root_q <= is_root_i;
      t_q[0] <= sat32(36'(offset_x_i) + 36'(pos_x_i));
      t_q[1] <= sat32(36'(offset_y_i) + 36'(pos_y_i));
      t_q[2] <= sat32(36'(offset_z_i) + 36'(pos_z_i));
      ax_q <= angle_x_i; ay_q <= angle_y_i; az_q <= angle_z_i;
      for (int n = 0; n < 9; n++) pr_q[n] <= (n % 4 == 0) ? OneQ30 : 32'sd0;
      for (int n = 0; n < 3; n++) pp_q[n] <= 32'sd0;
    end
    if (state_q == StCor && cor_done) begin
      cs_q[ang_q] <= cor_c; sn_q[ang_q] <= cor_s;
    end
    prod_q <= 64'(mop_a) * 64'(mop_b);
    if (state_q == StMul && mv_q) begin
      if (k_q == 2'd0) begin
        if (ph_q == 2'd3) acc_q <= 36'(pp_q[i_q]) + rnd30(prod_q);
        else acc_q <= rnd30(prod_q);
      end else acc_q <= acc_n;
      if (last_k) begin
        unique case (ph_q)
          2'd0: a_q[4'(i_q) * 4'd3 + 4'(j_q)] <= sat32(acc_n);
          2'd1: l_q[4'(i_q) * 4'd3 + 4'(j_q)] <= sat32(acc_n);
          2'd2: w_q[4'(i_q) * 4'd3 + 4'(j_q)] <= sat32(acc_n);
          default: wp_q[i_q] <= sat32(acc_n);
        endcase
      end
    end
    if (state_q == StRdP) begin
      if (rd_q < 5'd9) rrd_q <= rot_mem[raddr];
      else if (rd_q < 5'd12) prd_q <= pos_mem[paddr];
      if (rd_q >= 5'd1 && rd_q <= 5'd9) pr_q[4'(rdm)] <= rrd_q;
      if (rd_q >= 5'd10) pp_q[2'(rdm - 5'd9)] <= prd_q;
    end
    if (state_q == StWr) begin
      if (wi_q < 4'd9) rot_mem[wra] <= w_q[wi_q];
      else pos_mem[wpa] <= wp_q[2'(wi_q - 4'd9)];
    end
  end

  // k==0 with prod of first term: acc starts fresh, or from pp_q[i] in phase 3;
  // prod_q is registered from the next indices, so i/j/k name the term in prod_q.

  assign in_stall_o = (state_q != StIdle);
  assign out_valid_o = ov_q;
  assign out_joint_o = jraw_q;
  assign world_x_o = wp_q[0];
  assign world_y_o = wp_q[1];
  assign world_z_o = wp_q[2];
  assign out_angle_x_o = ax_q;
  assign out_angle_y_o = ay_q;
  assign out_angle_z_o = az_q;

endmodule
